// File: hw/rtl/erq_pkg.sv
// Shared types and constants of the event report queue.
`default_nettype none

package erq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Fixed field widths
  localparam int TIME_W   = 32;
  localparam int EP_W     = 8;
  localparam int TYPE_W   = 3;
  localparam int PRESS_W  = 16;
  localparam int CLICK_W  = 8;
  localparam int DUR_W    = 16;
  localparam int LIMIT_W  = 5;
  localparam int SEQ_W    = 16;
  localparam int USED_W   = 5;
  localparam int DROP_W   = 32;
  localparam int PAYLOAD_W = 64;
  localparam int SLOT_W   = PAYLOAD_W + TIME_W + EP_W;

  localparam logic [TIME_W-1:0] TTL_RESET = 32'd30000;

  // Item kinds carried in the input tuser
  localparam logic MODE_EVENT = 1'b0;
  localparam logic MODE_LINK  = 1'b1;

  // Input tdata layout, last field in the lowest bits
  typedef struct packed {
    logic [6:0]         pad;
    logic [LIMIT_W-1:0] accept_limit;
    logic               link_joined;
    logic [DUR_W-1:0]   duration;
    logic [CLICK_W-1:0] click_count;
    logic [PRESS_W-1:0] press_tag;
    logic [TYPE_W-1:0]  evt_code;
    logic [EP_W-1:0]    endpoint;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  // Output tdata layout, last field in the lowest bits
  typedef struct packed {
    logic [2:0]           pad;
    logic [DROP_W-1:0]    dropped_count;
    logic [USED_W-1:0]    queue_used;
    logic [PAYLOAD_W-1:0] payload_word;
    logic [EP_W-1:0]      out_endpoint;
  } out_item_t;

  localparam int IN_W  = $bits(in_item_t);
  localparam int OUT_W = $bits(out_item_t);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // latch the accepted item
    logic bump_seq;    // consume a sequence number
    logic set_joined;  // take the link status of the item
    logic enqueue;     // write the item into the ring, dropping the oldest if full
    logic read_head;   // issue a RAM read of the head slot
    logic discard;     // advance the head pointer
    logic push;        // stage the head entry as a result
    logic flush;       // release the staged result as the last of the run
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_event;
    logic joined;
    logic link_up;
    logic empty;
    logic expired;
    logic limit_hit;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/event_report_queue_with_ttl.sv
// Top level of the event report queue with time-to-live.
//
//   Channel   Signals                               Carries
//   --------  ------------------------------------  ---------------------------------
//   input     s_axis_tvalid/tready/tdata/tuser      event report or link status item
//   output    m_axis_tvalid/tready/tdata/tlast      one sent report, tlast on the last
//   config    cfg_wr_en/cfg_wr_data                 ttl_ms register
//
// An item is accepted and then decoded; for each queue entry visited by the
// drain the head is read from the slot RAM, then given the age and limit test.
// The drain ends when the queue is found empty or the limit is reached, and a
// closing state releases the last result.
// A held output stalls the drain only when a second result is ready to leave.
// Reset is synchronous; the slot RAM needs no clearing pass.
`default_nettype none

module event_report_queue_with_ttl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // Configuration
  input  wire logic                       cfg_wr_en,
  input  wire logic [erq_pkg::TIME_W-1:0] cfg_wr_data,
  // Input items
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // now_ms, endpoint, event code, press tag, click_count, duration,
  // link_joined, accept_limit, zero fill
  input  wire logic [erq_pkg::IN_W-1:0]   s_axis_tdata,
  // mode
  input  wire logic [0:0]                 s_axis_tuser,
  // Result items
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // out_endpoint, payload_word, queue_used, dropped_count, zero fill
  output logic [erq_pkg::OUT_W-1:0]       m_axis_tdata,
  // last_of_run
  output logic                            m_axis_tlast
);

  erq_pkg::cmd_t cmd;
  erq_pkg::sts_t sts;

  erq_controller u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  erq_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_data    (s_axis_tdata),
    .in_mode    (s_axis_tuser[0]),
    .out_ready  (m_axis_tready),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_axis_tvalid),
    .out_data   (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: hw/rtl/erq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module erq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/erq_datapath.sv
// Datapath: ring storage, pointers, counters, age test and result registers.
`default_nettype none

module erq_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [erq_pkg::TIME_W-1:0]    cfg_wr_data,
  input  wire logic [erq_pkg::IN_W-1:0]      in_data,
  input  wire logic                          in_mode,
  input  wire logic                          out_ready,
  input  wire erq_pkg::cmd_t                 cmd,
  output erq_pkg::sts_t                      sts,
  output logic                               out_valid,
  output logic [erq_pkg::OUT_W-1:0]          out_data,
  output logic                               out_last
);

  erq_pkg::in_item_t  in_item;
  erq_pkg::in_item_t  item;
  logic               item_mode;

  logic [erq_pkg::TIME_W-1:0]  ttl;
  logic [erq_pkg::PTR_W-1:0]   wr_ptr;
  logic [erq_pkg::PTR_W-1:0]   rd_ptr;
  logic [erq_pkg::CNT_W-1:0]   fill;
  logic [erq_pkg::DROP_W-1:0]  drops;
  logic [erq_pkg::SEQ_W-1:0]   seq;
  logic                        joined;
  logic [erq_pkg::LIMIT_W-1:0] sent;

  logic [erq_pkg::PTR_W-1:0]   wr_ptr_next;
  logic [erq_pkg::PTR_W-1:0]   rd_ptr_next;
  logic                        full;

  logic [erq_pkg::SLOT_W-1:0]    slot_wdata;
  logic [erq_pkg::SLOT_W-1:0]    slot_rdata;
  logic [erq_pkg::PAYLOAD_W-1:0] new_payload;
  logic [erq_pkg::EP_W-1:0]      head_ep;
  logic [erq_pkg::TIME_W-1:0]    head_time;
  logic [erq_pkg::PAYLOAD_W-1:0] head_payload;
  logic [erq_pkg::TIME_W-1:0]    head_age;

  erq_pkg::out_item_t pend;
  logic               pend_valid;
  erq_pkg::out_item_t out_item;

  assign in_item = erq_pkg::in_item_t'(in_data);

  // Pointer increments that wrap at the queue depth
  always_comb begin
    if (wr_ptr == erq_pkg::PTR_W'(erq_pkg::QUEUE_DEPTH - 1)) begin
      wr_ptr_next = '0;
    end else begin
      wr_ptr_next = wr_ptr + erq_pkg::PTR_W'(1);
    end
    if (rd_ptr == erq_pkg::PTR_W'(erq_pkg::QUEUE_DEPTH - 1)) begin
      rd_ptr_next = '0;
    end else begin
      rd_ptr_next = rd_ptr + erq_pkg::PTR_W'(1);
    end
  end

  assign full = (fill == erq_pkg::CNT_W'(erq_pkg::QUEUE_DEPTH));

  // Payload fields from the lowest bits: seq, press id, event type, click count, duration
  assign new_payload = {item.duration, item.click_count, 5'd0, item.evt_code,
                        item.press_tag, seq};
  assign slot_wdata  = {new_payload, item.now_ms, item.endpoint};

  // Slot storage
  erq_ram #(
    .WIDTH(erq_pkg::SLOT_W),
    .DEPTH(erq_pkg::QUEUE_DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (cmd.enqueue),
    .waddr(wr_ptr),
    .wdata(slot_wdata),
    .re   (cmd.read_head),
    .raddr(rd_ptr),
    .rdata(slot_rdata)
  );

  assign head_ep      = slot_rdata[erq_pkg::EP_W-1:0];
  assign head_time    = slot_rdata[erq_pkg::EP_W +: erq_pkg::TIME_W];
  assign head_payload = slot_rdata[erq_pkg::EP_W + erq_pkg::TIME_W +: erq_pkg::PAYLOAD_W];

  // Age wraps modulo 2^32; an age equal to the TTL is still live
  assign head_age = item.now_ms - head_time;

  // Status toward the controller
  always_comb begin
    sts.is_event   = (item_mode == erq_pkg::MODE_EVENT);
    sts.joined     = joined;
    sts.link_up    = item.link_joined;
    sts.empty      = (fill == '0);
    sts.expired    = (head_age > ttl);
    sts.limit_hit  = (sent >= item.accept_limit);
    sts.pend_valid = pend_valid;
    sts.out_free   = !out_valid || out_ready;
  end

  // Queue state, counters and captured item
  always_ff @(posedge clk) begin
    if (rst) begin
      ttl    <= erq_pkg::TTL_RESET;
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      drops  <= '0;
      seq    <= '0;
      joined <= 1'b0;
      sent   <= '0;
    end else begin
      if (cfg_wr_en) begin
        ttl <= cfg_wr_data;
      end
      if (cmd.capture) begin
        sent <= '0;
      end
      if (cmd.bump_seq) begin
        seq <= seq + erq_pkg::SEQ_W'(1);
      end
      if (cmd.set_joined) begin
        joined <= item.link_joined;
      end
      if (cmd.enqueue) begin
        wr_ptr <= wr_ptr_next;
        if (full) begin
          rd_ptr <= rd_ptr_next;
          drops  <= drops + erq_pkg::DROP_W'(1);
        end else begin
          fill <= fill + erq_pkg::CNT_W'(1);
        end
      end
      if (cmd.discard) begin
        rd_ptr <= rd_ptr_next;
        fill   <= fill - erq_pkg::CNT_W'(1);
      end
      if (cmd.push) begin
        sent <= sent + erq_pkg::LIMIT_W'(1);
      end
    end
  end

  // Item payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item      <= in_item;
      item_mode <= in_mode;
    end
  end

  // Staged result and output register; a staged result goes out as
  // last only when the controller knows no further send follows.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.push) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if ((cmd.push && pend_valid) || cmd.flush) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      pend.pad           <= '0;
      pend.out_endpoint  <= head_ep;
      pend.payload_word  <= head_payload;
      pend.queue_used    <= erq_pkg::USED_W'(fill - erq_pkg::CNT_W'(1));
      pend.dropped_count <= drops;
    end
    if (cmd.push && pend_valid) begin
      out_item <= pend;
      out_last <= 1'b0;
    end else if (cmd.flush) begin
      out_item <= pend;
      out_last <= 1'b1;
    end
  end

  assign out_data = out_item;

endmodule

`default_nettype wire

// File: hw/rtl/erq_controller.sv
// Controller: sequences decode, enqueue and the head-first drain.
`default_nettype none

module erq_controller (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire erq_pkg::sts_t sts,
  output erq_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_EVAL,
    ST_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.is_event) begin
          cmd.bump_seq = 1'b1;
          if (sts.joined) begin
            cmd.enqueue = 1'b1;
            state_next  = ST_READ;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          cmd.set_joined = 1'b1;
          state_next     = sts.link_up ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        if (sts.empty) begin
          state_next = ST_FLUSH;
        end else begin
          cmd.read_head = 1'b1;
          state_next    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // Expired entries go unsent; a live one is sent while the limit allows
        priority if (sts.expired) begin
          cmd.discard = 1'b1;
          state_next  = ST_READ;
        end else if (sts.limit_hit) begin
          state_next = ST_FLUSH;
        end else if (!sts.pend_valid || sts.out_free) begin
          cmd.push    = 1'b1;
          cmd.discard = 1'b1;
          state_next  = ST_READ;
        end else begin
          state_next = ST_EVAL;
        end
      end
      ST_FLUSH: begin
        priority if (!sts.pend_valid) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_FLUSH;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/erq_checker.sv
// Port-level checks of the event report queue, bound to the top level.
`default_nettype none

module erq_checker (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     s_axis_tvalid,
  input wire logic                     s_axis_tready,
  input wire logic                     m_axis_tvalid,
  input wire logic                     m_axis_tready,
  input wire logic [erq_pkg::OUT_W-1:0] m_axis_tdata,
  input wire logic                     m_axis_tlast
);

  // A held result keeps its contents until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // After reset the block is ready and shows no result.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> s_axis_tready && !m_axis_tvalid)
    else $error("block not quiet after reset");

  // A result that is not the last of its run means the run is still going.
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("new item taken in the middle of a run");

  // Ready drops after every accept while the accepted item is worked on.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high right after an accept");

endmodule

bind event_report_queue_with_ttl erq_checker u_erq_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire

// File: tb/erq_report_checker.sv
// Checker for the event report queue: predicts every sent report and compares the output stream.
`timescale 1ns / 100ps

module erq_report_checker
  import erq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [TIME_W-1:0]   cfg_wr_data,
  input  wire logic                s_axis_tvalid,
  input  wire logic                s_axis_tready,
  input  wire logic [IN_W-1:0]     s_axis_tdata,
  input  wire logic [0:0]          s_axis_tuser,
  input  wire logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  input  wire logic [OUT_W-1:0]    m_axis_tdata,
  input  wire logic                m_axis_tlast,
  output int                       fail_count,
  output int                       reports_pending,
  output int                       reports_checked,
  output int                       stale_discards,
  output logic [DROP_W-1:0]        overflow_drops
);

  // One expected report, as it should leave the block.
  typedef struct packed {
    logic [EP_W-1:0]      endpoint;
    logic [PAYLOAD_W-1:0] payload;
    logic                 last_flag;
    logic [USED_W-1:0]    used;
    logic [DROP_W-1:0]    dropped;
  } report_t;

  // Shadow copy of the ring and its bookkeeping.
  logic [EP_W-1:0]      ring_endpoint [QUEUE_DEPTH];
  logic [TIME_W-1:0]    ring_time     [QUEUE_DEPTH];
  logic [PAYLOAD_W-1:0] ring_payload  [QUEUE_DEPTH];
  logic [PTR_W-1:0]     head_ptr;
  logic [PTR_W-1:0]     tail_ptr;
  logic [CNT_W-1:0]     fill;
  logic [SEQ_W-1:0]     next_seq;
  logic                 link_up;
  logic [TIME_W-1:0]    ttl_limit;

  report_t awaited_reports [$];

  // Apply one accepted item to the shadow queue and append the reports it sends.
  task automatic forecast_reports(input logic mode, input in_item_t item);
    logic [PAYLOAD_W-1:0] word;
    logic [TIME_W-1:0]    age;
    report_t              rep;
    report_t              run [$];
    int                   sent;
    begin
      sent = 0;
      if (mode == MODE_EVENT) begin
        word = {item.duration, item.click_count, 5'b0, item.evt_code,
                item.press_tag, next_seq};
        next_seq = next_seq + 1'b1;
        if (!link_up) return;
        // A full ring gives up its oldest entry first.
        if (fill == QUEUE_DEPTH) begin
          head_ptr = head_ptr + 1'b1;
          fill = fill - 1'b1;
          overflow_drops = overflow_drops + 1'b1;
        end
        ring_endpoint[tail_ptr] = item.endpoint;
        ring_time[tail_ptr] = item.now_ms;
        ring_payload[tail_ptr] = word;
        tail_ptr = tail_ptr + 1'b1;
        fill = fill + 1'b1;
      end else begin
        link_up = item.link_joined;
        if (!link_up) return;
      end
      // Drain from the head: stale entries vanish, live ones go out until the limit.
      while (fill != 0) begin
        age = item.now_ms - ring_time[head_ptr];
        if (age > ttl_limit) begin
          head_ptr = head_ptr + 1'b1;
          fill = fill - 1'b1;
          stale_discards++;
          continue;
        end
        if (sent >= item.accept_limit) break;
        rep.endpoint = ring_endpoint[head_ptr];
        rep.payload = ring_payload[head_ptr];
        rep.last_flag = 1'b0;
        head_ptr = head_ptr + 1'b1;
        fill = fill - 1'b1;
        rep.used = fill;
        rep.dropped = overflow_drops;
        run.push_back(rep);
        sent++;
      end
      for (int i = 0; i < run.size(); i++) begin
        rep = run[i];
        rep.last_flag = (i == run.size() - 1);
        awaited_reports.push_back(rep);
      end
    end
  endtask

  // Track configuration and items on the input side, check reports on the output side.
  always @(posedge clk) begin : watch_proc
    out_item_t got;
    report_t   want;
    if (rst) begin
      head_ptr = '0;
      tail_ptr = '0;
      fill = '0;
      next_seq = '0;
      link_up = 1'b0;
      ttl_limit = TTL_RESET;
      overflow_drops = '0;
      awaited_reports.delete();
    end else begin
      if (cfg_wr_en) ttl_limit = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        forecast_reports(s_axis_tuser[0], in_item_t'(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = out_item_t'(m_axis_tdata);
        reports_checked++;
        if (awaited_reports.size() == 0) begin
          $display("%0t: unexpected report ep=%h payload=%h last=%b used=%0d drops=%0d",
                   $time, got.out_endpoint, got.payload_word, m_axis_tlast,
                   got.queue_used, got.dropped_count);
          fail_count++;
        end else begin
          want = awaited_reports.pop_front();
          if (got.out_endpoint !== want.endpoint || got.payload_word !== want.payload ||
              m_axis_tlast !== want.last_flag || got.queue_used !== want.used ||
              got.dropped_count !== want.dropped) begin
            $display("%0t: report mismatch", $time);
            $display("  expected ep=%h payload=%h last=%b used=%0d drops=%0d",
                     want.endpoint, want.payload, want.last_flag, want.used, want.dropped);
            $display("  actual   ep=%h payload=%h last=%b used=%0d drops=%0d",
                     got.out_endpoint, got.payload_word, m_axis_tlast, got.queue_used,
                     got.dropped_count);
            fail_count++;
          end
        end
      end
    end
    reports_pending = awaited_reports.size();
  end

endmodule

// File: tb/testbench.sv
// Top of the event report queue testbench: clock, reset, stimulus, pacing and verdict.
`timescale 1ns / 100ps

module testbench;
  import erq_pkg::*;

  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 80;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [TIME_W-1:0]   cfg_wr_data;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata;
  logic [0:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic                m_axis_tlast;

  int                  fail_count;
  int                  reports_pending;
  int                  reports_checked;
  int                  stale_discards;
  logic [DROP_W-1:0]   overflow_drops;

  int                  send_idle_pct;
  int                  stall_pct;
  int                  hold_requests;
  int                  items_offered;
  int                  idle_cycles;
  logic [TIME_W-1:0]   now_cur;
  logic [TIME_W-1:0]   ttl_cur;

  event_report_queue_with_ttl u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  erq_report_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast),
    .fail_count      (fail_count),
    .reports_pending (reports_pending),
    .reports_checked (reports_checked),
    .stale_discards  (stale_discards),
    .overflow_drops  (overflow_drops)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort when neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, no item moved in %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Output side: random stalls, plus a long hold-off whenever the stimulus asks for one.
  initial begin : sink_proc
    int hold_left;
    int holds_seen;
    hold_left = 0;
    holds_seen = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic in_item_t build_item(input logic [TIME_W-1:0] now, input logic [7:0] ep,
                                          input logic [2:0] kind, input logic [15:0] press,
                                          input logic [7:0] clicks, input logic [15:0] dur,
                                          input logic joined, input logic [4:0] limit);
    in_item_t item;
    item = '0;
    item.now_ms = now;
    item.endpoint = ep;
    item.evt_code = kind;
    item.press_tag = press;
    item.click_count = clicks;
    item.duration = dur;
    item.link_joined = joined;
    item.accept_limit = limit;
    return item;
  endfunction

  // Offer one item after a random idle gap and wait for its acceptance.
  task automatic offer(input logic mode, input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= item;
    s_axis_tuser <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_offered++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected report is out and the drain has ended.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_ttl(input logic [TIME_W-1:0] value);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    ttl_cur = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly joined-link event traffic with random content; some link drops and odd limits.
  task automatic offer_random();
    int          pick;
    logic        mode;
    logic [2:0]  kind;
    logic [4:0]  limit;
    pick = $urandom_range(99);
    if (pick < 35) begin
    end else if (pick < 80) begin
      now_cur = now_cur + $urandom_range(1, 400);
    end else if (pick < 92) begin
      now_cur = now_cur + ttl_cur + $urandom_range(1);
    end else begin
      now_cur = $urandom();
    end
    mode = ($urandom_range(99) < 12) ? MODE_LINK : MODE_EVENT;
    kind = ($urandom_range(99) < 85) ? 3'($urandom_range(4)) : 3'($urandom_range(5, 7));
    pick = $urandom_range(99);
    if (pick < 35) limit = 5'd0;
    else if (pick < 65) limit = 5'($urandom_range(1, 3));
    else if (pick < 85) limit = 5'd16;
    else limit = 5'($urandom_range(31));
    offer(mode, build_item(now_cur, 8'($urandom()), kind, 16'($urandom()), 8'($urandom()),
                           16'($urandom()),
                           (mode == MODE_LINK) ? ($urandom_range(99) < 75)
                                               : 1'($urandom_range(1)),
                           limit));
  endtask

  task automatic run_phase(input int idle_pct, input int stall, input bit with_hold);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (with_hold && i == 20) hold_requests++;
      offer_random();
    end
  endtask

  // Main stimulus and verdict.
  initial begin : stim_proc
    logic [TIME_W-1:0] ttl_mixed;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = MODE_EVENT;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_requests = 0;
    items_offered = 0;
    ttl_cur = TTL_RESET;
    now_cur = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Event while the link is down still consumes a sequence number.
    offer(MODE_EVENT, build_item('1, 8'hFF, 3'd7, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 5'd31));
    offer(MODE_LINK, build_item('0, 8'h00, 3'd0, 16'h0000, 8'h00, 16'h0000, 1'b0, 5'd16));
    // Join with an empty queue sends nothing.
    offer(MODE_LINK, build_item('0, 8'h00, 3'd0, 16'h0000, 8'h00, 16'h0000, 1'b1, 5'd0));
    offer(MODE_EVENT, build_item('0, 8'h00, 3'd0, 16'h0000, 8'h00, 16'h0000, 1'b0, 5'd31));
    // An entry exactly at its lifetime is still sent; one past it is dropped silently.
    offer(MODE_EVENT, build_item(32'd100, 8'h01, 3'd4, 16'h1234, 8'h03, 16'h0000, 1'b0, 5'd0));
    offer(MODE_LINK, build_item(32'd30100, 8'h00, 3'd0, 16'h0000, 8'h00, 16'h0000, 1'b1,
                                5'd16));
    offer(MODE_EVENT, build_item(32'd200, 8'h02, 3'd3, 16'h5678, 8'h00, 16'h0BB8, 1'b1, 5'd0));
    offer(MODE_LINK, build_item(32'd30201, 8'h00, 3'd0, 16'h0000, 8'h00, 16'h0000, 1'b1,
                                5'd16));
    // Overfill the ring just before the time counter wraps.
    for (int i = 0; i < QUEUE_DEPTH + 1; i++) begin
      offer(MODE_EVENT, build_item(32'hFFFF_FFF0 + i, 8'(i), 3'(i), 16'($urandom()),
                                   8'(i * 9), 16'($urandom()), 1'($urandom_range(1)), 5'd0));
    end
    // Partial drain across the wrap, then an enqueue that finds every older entry stale.
    offer(MODE_LINK, build_item(32'h10, 8'h00, 3'd0, 16'h0000, 8'h00, 16'h0000, 1'b1, 5'd3));
    offer(MODE_EVENT, build_item(32'd30116, 8'hA5, 3'd2, 16'hBEEF, 8'h00, 16'h0000, 1'b0,
                                 5'd0));
    offer(MODE_LINK, build_item(32'd30116, 8'h00, 3'd0, 16'h0000, 8'h00, 16'h0000, 1'b1,
                                5'd16));
    now_cur = 32'd40000;

    // Random traffic under four pacing regimes and lifetimes.
    run_phase(0, 0, 1'b1);
    write_ttl('0);
    run_phase(61, 0, 1'b0);
    write_ttl('1);
    run_phase(0, 61, 1'b0);
    ttl_mixed = $urandom_range(50, 3000);
    write_ttl(ttl_mixed);
    run_phase(15, 15, 1'b0);
    settle();

    $display("Summary: %0d items offered, %0d reports checked, %0d stale entries discarded,",
             items_offered, reports_checked, stale_discards);
    $display("  %0d overflow drops; lifetimes 30000, 0, max and %0d ms, with a long sink hold.",
             overflow_drops, ttl_mixed);
    if (fail_count == 0 && reports_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/erq_pkg.sv
hw/rtl/erq_ram.sv
hw/rtl/erq_datapath.sv
hw/rtl/erq_controller.sv
hw/rtl/event_report_queue_with_ttl.sv
hw/rtl/erq_checker.sv
tb/erq_report_checker.sv
tb/testbench.sv
